>>> design/rhcm_pkg.sv
// ----------------------------------------------------------------------------
// rhcm_pkg
// Shared types and constants of the RGB/HSL channel mixer.
// ----------------------------------------------------------------------------
package rhcm_pkg;

    localparam int COEF_W        = 16;
    localparam int COEF_REG_W    = 3 * COEF_W;
    localparam int CFG_INDEX_W   = 3;
    localparam int SAMPLE_W_DEF  = 18;
    localparam int ONE_Q14       = 16384;
    localparam int HSL_W         = 15;
    localparam int HSLRGB_W      = 19;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HUE   = 3'd0,
        CFG_SAT   = 3'd1,
        CFG_LIGHT = 3'd2,
        CFG_RED   = 3'd3,
        CFG_GREEN = 3'd4,
        CFG_BLUE  = 3'd5,
        CFG_GRAY  = 3'd6
    } rhcm_cfg_index_t;

    localparam logic [COEF_REG_W-1:0] RED_RESET   = 48'h0000_0000_1000;
    localparam logic [COEF_REG_W-1:0] GREEN_RESET = 48'h0000_1000_0000;
    localparam logic [COEF_REG_W-1:0] BLUE_RESET  = 48'h1000_0000_0000;

    // Segment of the hue circle that one output channel falls in.
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_FLAT,
        SEG_FALL,
        SEG_LOW
    } rhcm_seg_t;

endpackage

>>> design/rgb_hsl_channel_mixer.sv
// ----------------------------------------------------------------------------
// rgb_hsl_channel_mixer
// RGB channel mixer with HSL and monochrome paths, ten-stage pipeline.
// ----------------------------------------------------------------------------
// The mixer takes one RGB word per clock and returns one mixed RGB word per
// clock while the output is not stalled, through its ten register stages
// (first row mix, clip, four stages of HSL to RGB conversion, second row mix
// and the saturating output register). The whole pipeline advances together
// whenever the output register is empty or being taken, so s_ready is low only
// while a finished word waits on m_ready. The mode follows from the
// coefficient registers: a nonzero gray row gives monochrome output, otherwise
// a nonzero hue, saturation or lightness row enables the HSL path, otherwise
// the red, green and blue rows form a plain 3x3 matrix. Coefficients are to be
// written only while the pipeline is empty.
module rgb_hsl_channel_mixer
    import rhcm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [COEF_REG_W-1:0]          cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_in_red,
    input  logic signed [SAMPLE_WIDTH-1:0] s_in_green,
    input  logic signed [SAMPLE_WIDTH-1:0] s_in_blue,
    input  logic                           s_pixel_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_out_red,
    output logic signed [SAMPLE_WIDTH-1:0] m_out_green,
    output logic signed [SAMPLE_WIDTH-1:0] m_out_blue,
    output logic                           m_out_last
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int MIX_W = SW + 6;
    localparam int S2W   = (SW > HSLRGB_W) ? SW : HSLRGB_W;
    localparam int MIX2_W = S2W + 6;
    localparam int LAT   = 10;
    localparam longint SAT_HI = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    logic [COEF_REG_W-1:0] coef_reg [7];
    logic                  gray_mode, hsl_path_en, ce;
    logic [LAT-1:0]        vld_reg;

    // Configuration registers; writes beyond the gray row are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[CFG_HUE]   <= '0;
            coef_reg[CFG_SAT]   <= '0;
            coef_reg[CFG_LIGHT] <= '0;
            coef_reg[CFG_RED]   <= RED_RESET;
            coef_reg[CFG_GREEN] <= GREEN_RESET;
            coef_reg[CFG_BLUE]  <= BLUE_RESET;
            coef_reg[CFG_GRAY]  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HUE:   coef_reg[CFG_HUE]   <= cfg_data;
                CFG_SAT:   coef_reg[CFG_SAT]   <= cfg_data;
                CFG_LIGHT: coef_reg[CFG_LIGHT] <= cfg_data;
                CFG_RED:   coef_reg[CFG_RED]   <= cfg_data;
                CFG_GREEN: coef_reg[CFG_GREEN] <= cfg_data;
                CFG_BLUE:  coef_reg[CFG_BLUE]  <= cfg_data;
                CFG_GRAY:  coef_reg[CFG_GRAY]  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign gray_mode   = |coef_reg[CFG_GRAY];
    assign hsl_path_en = |coef_reg[CFG_HUE] | |coef_reg[CFG_SAT] | |coef_reg[CFG_LIGHT];

    // One enable for every stage: the pipeline moves when the output slot frees.
    assign ce      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = ce;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // First mix: hue, saturation, lightness and gray rows.
    logic signed [MIX_W-1:0] h_mix, s_mix, l_mix, g_mix;

    rhcm_row_mix #(.SRC_W(SW)) u_mix_hue (
        .aclk(aclk), .ce(ce), .weights(coef_reg[CFG_HUE]),
        .src0(s_in_red), .src1(s_in_green), .src2(s_in_blue), .mix_reg(h_mix)
    );
    rhcm_row_mix #(.SRC_W(SW)) u_mix_sat (
        .aclk(aclk), .ce(ce), .weights(coef_reg[CFG_SAT]),
        .src0(s_in_red), .src1(s_in_green), .src2(s_in_blue), .mix_reg(s_mix)
    );
    rhcm_row_mix #(.SRC_W(SW)) u_mix_light (
        .aclk(aclk), .ce(ce), .weights(coef_reg[CFG_LIGHT]),
        .src0(s_in_red), .src1(s_in_green), .src2(s_in_blue), .mix_reg(l_mix)
    );
    rhcm_row_mix #(.SRC_W(SW)) u_mix_gray (
        .aclk(aclk), .ce(ce), .weights(coef_reg[CFG_GRAY]),
        .src0(s_in_red), .src1(s_in_green), .src2(s_in_blue), .mix_reg(g_mix)
    );

    // Stage three: clip H, S and L to the unit range, saturate the gray mix.
    logic [HSL_W-1:0]        h_reg, s_reg, l_reg, h_next, s_next, l_next;
    logic signed [SW-1:0]    g_next;
    logic signed [SW-1:0]    g_dly_reg [7];

    always_comb begin
        if (h_mix < 0)             h_next = '0;
        else if (h_mix > ONE_Q14)  h_next = HSL_W'(ONE_Q14);
        else                       h_next = h_mix[HSL_W-1:0];
        if (s_mix < 0)             s_next = '0;
        else if (s_mix > ONE_Q14)  s_next = HSL_W'(ONE_Q14);
        else                       s_next = s_mix[HSL_W-1:0];
        if (l_mix < 0)             l_next = '0;
        else if (l_mix > ONE_Q14)  l_next = HSL_W'(ONE_Q14);
        else                       l_next = l_mix[HSL_W-1:0];
        if (g_mix > SAT_HI)        g_next = SW'(SAT_HI);
        else if (g_mix < SAT_LO)   g_next = SW'(SAT_LO);
        else                       g_next = g_mix[SW-1:0];
    end

    // Side delay lines keep samples, gray value and frame marker aligned.
    logic signed [SW-1:0] px_dly_reg [7][3];
    logic [LAT-2:0]       last_dly_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            h_reg <= h_next;
            s_reg <= s_next;
            l_reg <= l_next;
            g_dly_reg[0] <= g_next;
            for (int i = 1; i < 7; i++) begin
                g_dly_reg[i] <= g_dly_reg[i-1];
            end
            px_dly_reg[0][0] <= s_in_red;
            px_dly_reg[0][1] <= s_in_green;
            px_dly_reg[0][2] <= s_in_blue;
            for (int i = 1; i < 7; i++) begin
                px_dly_reg[i] <= px_dly_reg[i-1];
            end
            last_dly_reg <= {last_dly_reg[LAT-3:0], s_pixel_last};
        end
    end

    // Stages four to seven: HSL to RGB.
    logic signed [HSLRGB_W-1:0] hsl_rgb [3];

    rhcm_hsl2rgb u_hsl2rgb (
        .aclk(aclk), .ce(ce), .hue(h_reg), .sat(s_reg), .light(l_reg),
        .rgb_reg(hsl_rgb)
    );

    // Source of the RGB matrix: converted HSL or the delayed input pixel.
    logic signed [S2W-1:0] src [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (hsl_path_en) begin
                src[c] = S2W'(hsl_rgb[c]);
            end else begin
                src[c] = S2W'(px_dly_reg[6][c]);
            end
        end
    end

    // Stages eight and nine: the red, green and blue rows.
    logic signed [MIX2_W-1:0] r_mix, gr_mix, b_mix;

    rhcm_row_mix #(.SRC_W(S2W)) u_mix_red (
        .aclk(aclk), .ce(ce), .weights(coef_reg[CFG_RED]),
        .src0(src[0]), .src1(src[1]), .src2(src[2]), .mix_reg(r_mix)
    );
    rhcm_row_mix #(.SRC_W(S2W)) u_mix_green (
        .aclk(aclk), .ce(ce), .weights(coef_reg[CFG_GREEN]),
        .src0(src[0]), .src1(src[1]), .src2(src[2]), .mix_reg(gr_mix)
    );
    rhcm_row_mix #(.SRC_W(S2W)) u_mix_blue (
        .aclk(aclk), .ce(ce), .weights(coef_reg[CFG_BLUE]),
        .src0(src[0]), .src1(src[1]), .src2(src[2]), .mix_reg(b_mix)
    );

    // Stage ten: saturate, pick monochrome or colour, register the output word.
    logic signed [SW-1:0] r_sat, g_sat, b_sat;
    logic signed [SW-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic                 out_last_reg;

    always_comb begin
        if (r_mix > SAT_HI)        r_sat = SW'(SAT_HI);
        else if (r_mix < SAT_LO)   r_sat = SW'(SAT_LO);
        else                       r_sat = r_mix[SW-1:0];
        if (gr_mix > SAT_HI)       g_sat = SW'(SAT_HI);
        else if (gr_mix < SAT_LO)  g_sat = SW'(SAT_LO);
        else                       g_sat = gr_mix[SW-1:0];
        if (b_mix > SAT_HI)        b_sat = SW'(SAT_HI);
        else if (b_mix < SAT_LO)   b_sat = SW'(SAT_LO);
        else                       b_sat = b_mix[SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_red_reg   <= gray_mode ? g_dly_reg[6] : r_sat;
            out_green_reg <= gray_mode ? g_dly_reg[6] : g_sat;
            out_blue_reg  <= gray_mode ? g_dly_reg[6] : b_sat;
            out_last_reg  <= last_dly_reg[LAT-2];
        end
    end

    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;
    assign m_out_last  = out_last_reg;

endmodule

>>> design/rhcm_row_mix.sv
// ----------------------------------------------------------------------------
// rhcm_row_mix
// One weighted sum of three samples: products, then sum with rounding.
// ----------------------------------------------------------------------------
module rhcm_row_mix
    import rhcm_pkg::*;
#(
    parameter int SRC_W = SAMPLE_W_DEF
) (
    input  logic                    aclk,
    input  logic                    ce,
    input  logic [COEF_REG_W-1:0]   weights,
    input  logic signed [SRC_W-1:0] src0,
    input  logic signed [SRC_W-1:0] src1,
    input  logic signed [SRC_W-1:0] src2,
    output logic signed [SRC_W+5:0] mix_reg
);

    localparam int PROD_W = SRC_W + COEF_W;
    localparam int ACC_W  = PROD_W + 2;

    logic signed [COEF_W-1:0] w0, w1, w2;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SRC_W+5:0]  mix_next;

    assign w0 = signed'(weights[0*COEF_W +: COEF_W]);
    assign w1 = signed'(weights[1*COEF_W +: COEF_W]);
    assign w2 = signed'(weights[2*COEF_W +: COEF_W]);

    assign p0_next = w0 * src0;
    assign p1_next = w1 * src1;
    assign p2_next = w2 * src2;

    // Round half up to Q.14 by adding half an LSB and dropping twelve bits.
    assign acc = ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg)
               + ACC_W'(signed'(32'sd2048));
    assign mix_next = acc[ACC_W-1:12];

    always_ff @(posedge aclk) begin
        if (ce) begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            mix_reg <= mix_next;
        end
    end

endmodule

>>> design/rhcm_hsl2rgb.sv
// ----------------------------------------------------------------------------
// rhcm_hsl2rgb
// Four-stage HSL to RGB conversion on clipped Q.14 values.
// ----------------------------------------------------------------------------
module rhcm_hsl2rgb
    import rhcm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       ce,
    input  logic [HSL_W-1:0]           hue,
    input  logic [HSL_W-1:0]           sat,
    input  logic [HSL_W-1:0]           light,
    output logic signed [HSLRGB_W-1:0] rgb_reg [3]
);

    localparam logic signed [HSLRGB_W-1:0] ONE_S  = HSLRGB_W'(ONE_Q14);
    localparam logic signed [HSLRGB_W-1:0] SIX_S  = HSLRGB_W'(6 * ONE_Q14);

    // Stage 1: l*s
    logic [HSL_W-1:0] h1_reg, s1_reg, l1_reg, ls1_reg, ls1_next;

    // Stage 2: m1, m2 and the segment of each channel
    logic signed [HSLRGB_W-1:0] m1_2_reg, m2_2_reg, m1_2_next, m2_2_next;
    logic [15:0]                d2_reg, d2_next;
    rhcm_seg_t                  seg2_reg [3];
    rhcm_seg_t                  seg2_next [3];
    logic [HSL_W-1:0]           f2_reg [3];
    logic [HSL_W-1:0]           f2_next [3];
    logic signed [HSLRGB_W-1:0] h6;
    logic signed [HSLRGB_W-1:0] hx [3];
    logic signed [HSLRGB_W-1:0] off [3];

    // Stage 3: ramp products
    logic signed [HSLRGB_W-1:0] m1_3_reg, m2_3_reg;
    rhcm_seg_t                  seg3_reg [3];
    logic [16:0]                r3_reg [3];
    logic [16:0]                r3_next [3];
    logic [31:0]                r_full [3];

    logic signed [HSLRGB_W-1:0] rgb_next [3];

    always_comb begin
        ls1_next = HSL_W'((31'(light) * 31'(sat) + 31'd8192) >> 14);
    end

    always_comb begin
        logic signed [HSLRGB_W-1:0] ls, l, s;
        ls = HSLRGB_W'(ls1_reg);
        l  = HSLRGB_W'(l1_reg);
        s  = HSLRGB_W'(s1_reg);
        if (l1_reg < HSL_W'(ONE_Q14 / 2)) begin
            m2_2_next = l + ls;
        end else begin
            m2_2_next = l + s - ls;
        end
        m1_2_next = (l <<< 1) - m2_2_next;
        d2_next   = 16'(m2_2_next - m1_2_next);
        h6        = HSLRGB_W'(h1_reg) * HSLRGB_W'(6);
        off[0]    = HSLRGB_W'(2 * ONE_Q14);
        off[1]    = '0;
        off[2]    = -HSLRGB_W'(2 * ONE_Q14);
        for (int c = 0; c < 3; c++) begin
            hx[c] = h6 + off[c];
            if (hx[c] < 0) begin
                hx[c] = hx[c] + SIX_S;
            end else if (hx[c] > SIX_S) begin
                hx[c] = hx[c] - SIX_S;
            end
            f2_next[c] = '0;
            priority if (hx[c] < ONE_S) begin
                seg2_next[c] = SEG_RISE;
                f2_next[c]   = HSL_W'(hx[c]);
            end else if (hx[c] < 3 * ONE_S) begin
                seg2_next[c] = SEG_FLAT;
            end else if (hx[c] < 4 * ONE_S) begin
                seg2_next[c] = SEG_FALL;
                f2_next[c]   = HSL_W'(4 * ONE_S - hx[c]);
            end else begin
                seg2_next[c] = SEG_LOW;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            r_full[c]  = 32'(d2_reg) * 32'(f2_reg[c]) + 32'd8192;
            r3_next[c] = r_full[c][30:14];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            unique case (seg3_reg[c])
                SEG_RISE, SEG_FALL: rgb_next[c] = m1_3_reg + HSLRGB_W'(r3_reg[c]);
                SEG_FLAT:           rgb_next[c] = m2_3_reg;
                default:            rgb_next[c] = m1_3_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            h1_reg   <= hue;
            s1_reg   <= sat;
            l1_reg   <= light;
            ls1_reg  <= ls1_next;
            m1_2_reg <= m1_2_next;
            m2_2_reg <= m2_2_next;
            d2_reg   <= d2_next;
            m1_3_reg <= m1_2_reg;
            m2_3_reg <= m2_2_reg;
            for (int c = 0; c < 3; c++) begin
                seg2_reg[c] <= seg2_next[c];
                f2_reg[c]   <= f2_next[c];
                seg3_reg[c] <= seg2_reg[c];
                r3_reg[c]   <= r3_next[c];
                rgb_reg[c]  <= rgb_next[c];
            end
        end
    end

endmodule

>>> design/rhcm_checker.sv
// ----------------------------------------------------------------------------
// rhcm_checker
// Port-level assertions for the channel mixer, bound to the top level.
// ----------------------------------------------------------------------------
module rhcm_checker
    import rhcm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_out_red,
    input logic signed [SAMPLE_WIDTH-1:0] m_out_green,
    input logic signed [SAMPLE_WIDTH-1:0] m_out_blue,
    input logic                           m_out_last
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    // A stalled output word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red)
            && $stable(m_out_green) && $stable(m_out_blue) && $stable(m_out_last))
        else $error("stalled output word changed");

    // The input side stalls only while a finished word is held back.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && !m_ready) |-> s_ready)
        else $error("input stalled with output free");

    a_ready_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

bind rgb_hsl_channel_mixer rhcm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_rhcm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_out_red(m_out_red), .m_out_green(m_out_green),
    .m_out_blue(m_out_blue), .m_out_last(m_out_last)
);
